FILE: rtl/rti_pkg.sv
// rti_pkg: widths, outcome codes and the queue item type for the ray/triangle test
// depends on nothing; used by every module of the block except rti_queue
`default_nettype none

package rti_pkg;

	localparam int COMP_W = 21;   // one Q10.10 component
	localparam int VEC_W  = 63;   // three packed components
	localparam int TOL_W  = 20;
	localparam int DOT_W  = 70;   // det, nu, nv, nt at 2^-30
	localparam int CMP_W  = 92;   // tolerance compares at 2^-46
	localparam int NRM_W  = 47;
	localparam int DIST_W = 32;   // t as Q16.16
	localparam int REM_W  = 102;  // divider remainder, below det << 32
	localparam int FRAC_T = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 20'd1;

	typedef enum logic [2:0] {
		OUT_HIT       = 3'd0,
		OUT_PARALLEL  = 3'd1,
		OUT_U_OUTSIDE = 3'd2,
		OUT_V_OUTSIDE = 3'd3,
		OUT_BEHIND    = 3'd4
	} outcome_t;

	// classified test handed from the front pipeline to the divider side
	typedef struct packed {
		outcome_t                 outcome;
		logic signed [DOT_W-1:0]  num;
		logic signed [DOT_W-1:0]  den;
		logic [VEC_W-1:0]         org;
		logic [VEC_W-1:0]         dir;
		logic signed [NRM_W-1:0]  nrm_x;
		logic signed [NRM_W-1:0]  nrm_y;
		logic signed [NRM_W-1:0]  nrm_z;
	} q_item_t;

	function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] word,
		input int unsigned k);
		return $signed(word[k*COMP_W +: COMP_W]);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rti_queue.sv
// rti_queue: small register queue between the front pipeline and the divider side
// depends on nothing; width and depth come from the instantiating module
`default_nettype none

module rti_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rti_front.sv
// rti_front: nine-stage pipeline forming edges, cross and dot products and the outcome
// depends on rti_pkg; feeds rti_queue
`default_nettype none

module rti_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rti_pkg::TOL_W-1:0]    tolerance,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [rti_pkg::VEC_W-1:0]    ray_origin,
	input  logic [rti_pkg::VEC_W-1:0]    ray_direction,
	input  logic [rti_pkg::VEC_W-1:0]    vertex_a,
	input  logic [rti_pkg::VEC_W-1:0]    vertex_b,
	input  logic [rti_pkg::VEC_W-1:0]    vertex_c,
	input  logic                         queue_full,
	output logic                         push,
	output rti_pkg::q_item_t             push_item
);

	localparam int STAGES = 9;
	localparam int DW = rti_pkg::DOT_W;
	localparam int CW = rti_pkg::CMP_W;

	typedef struct packed {
		logic [rti_pkg::VEC_W-1:0]        org;
		logic [rti_pkg::VEC_W-1:0]        dir;
		logic signed [rti_pkg::NRM_W-1:0] nrm_x;
		logic signed [rti_pkg::NRM_W-1:0] nrm_y;
		logic signed [rti_pkg::NRM_W-1:0] nrm_z;
	} side_t;

	function automatic logic signed [46:0] mul_lo(input logic signed [21:0] a,
		input logic [22:0] b);
		return 47'(a) * 47'($signed({1'b0, b}));
	endfunction

	function automatic logic signed [44:0] mul_hi(input logic signed [21:0] a,
		input logic signed [21:0] b);
		return 45'(a) * 45'(b);
	endfunction

	function automatic logic signed [DW-1:0] dot_sum(
		input logic signed [46:0] l0, input logic signed [44:0] h0,
		input logic signed [46:0] l1, input logic signed [44:0] h1,
		input logic signed [46:0] l2, input logic signed [44:0] h2);
		return DW'(l0) + (DW'(h0) <<< 23) + DW'(l1) + (DW'(h1) <<< 23)
			+ DW'(l2) + (DW'(h2) <<< 23);
	endfunction

	logic [STAGES:1] valid_s;
	logic            en;

	assign en       = !valid_s[STAGES] || !queue_full;
	assign in_stall = !en;
	assign push     = valid_s[STAGES] && !queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[STAGES-1:1], in_valid};
		end
	end

	// stage 1: unpack and edges
	logic [rti_pkg::VEC_W-1:0] org_s1, dir_raw_s1;
	logic signed [20:0] dir_s1 [3];
	logic signed [21:0] e1_s1 [3], e2_s1 [3], sv_s1 [3];

	// stage 2: cross products
	logic signed [43:0] p_s2 [3];
	logic signed [44:0] q_s2 [3];
	logic signed [21:0] e1_s2 [3], e2_s2 [3], sv_s2 [3], dir_s2 [3];
	side_t side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;

	// stage 3: split products of the dots
	logic signed [46:0] det_lo_s3 [3], nu_lo_s3 [3], nv_lo_s3 [3], nt_lo_s3 [3];
	logic signed [44:0] det_hi_s3 [3], nu_hi_s3 [3], nv_hi_s3 [3], nt_hi_s3 [3];

	logic signed [DW-1:0] det_s4, nu_s4, nv_s4, nt_s4;
	logic signed [DW-1:0] det_s5, nu_s5, nv_s5, nt_s5;
	logic signed [DW-1:0] det_s6, nu_s6, nv_s6, nt_s6;
	logic signed [DW-1:0] det_s7, nu_s7, nv_s7, nt_s7;
	logic signed [DW-1:0] det_s8, nu_s8, nv_s8, nt_s8;
	logic signed [DW-1:0] det_s9, nt_s9;
	logic [42:0]          pp_s6 [3];
	logic                 par_s6, par_s7, par_s8;
	logic signed [CW-1:0] dt_s7, dt_s8, one_e_s8, neg_e_s8;
	rti_pkg::outcome_t    outcome_s9;
	rti_pkg::outcome_t    outcome_d;
	logic signed [CW-1:0] nu16, nv16, nt16, uv16;

	always_ff @(posedge clk) begin
		if (en) begin
			org_s1     <= ray_origin;
			dir_raw_s1 <= ray_direction;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_vec
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;

		always_ff @(posedge clk) begin
			if (en) begin
				dir_s1[k] <= rti_pkg::comp(ray_direction, k);
				e1_s1[k]  <= 22'(rti_pkg::comp(vertex_b, k)) - 22'(rti_pkg::comp(vertex_a, k));
				e2_s1[k]  <= 22'(rti_pkg::comp(vertex_c, k)) - 22'(rti_pkg::comp(vertex_a, k));
				sv_s1[k]  <= 22'(rti_pkg::comp(ray_origin, k)) - 22'(rti_pkg::comp(vertex_a, k));

				p_s2[k]   <= 44'(dir_s1[K1]) * 44'(e2_s1[K2]) - 44'(dir_s1[K2]) * 44'(e2_s1[K1]);
				q_s2[k]   <= 45'(sv_s1[K1]) * 45'(e1_s1[K2]) - 45'(sv_s1[K2]) * 45'(e1_s1[K1]);
				e1_s2[k]  <= e1_s1[k];
				e2_s2[k]  <= e2_s1[k];
				sv_s2[k]  <= sv_s1[k];
				dir_s2[k] <= 22'(dir_s1[k]);

				det_lo_s3[k] <= mul_lo(e1_s2[k], p_s2[k][22:0]);
				det_hi_s3[k] <= mul_hi(e1_s2[k], 22'($signed(p_s2[k][43:23])));
				nu_lo_s3[k]  <= mul_lo(sv_s2[k], p_s2[k][22:0]);
				nu_hi_s3[k]  <= mul_hi(sv_s2[k], 22'($signed(p_s2[k][43:23])));
				nv_lo_s3[k]  <= mul_lo(dir_s2[k], q_s2[k][22:0]);
				nv_hi_s3[k]  <= mul_hi(dir_s2[k], $signed(q_s2[k][44:23]));
				nt_lo_s3[k]  <= mul_lo(e2_s2[k], q_s2[k][22:0]);
				nt_hi_s3[k]  <= mul_hi(e2_s2[k], $signed(q_s2[k][44:23]));

				// det * tolerance in three 23-bit slices
				pp_s6[k] <= 43'(det_s5[23*k +: 23]) * 43'(tolerance);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.org   <= org_s1;
			side_s2.dir   <= dir_raw_s1;
			side_s2.nrm_x <= 47'(45'(e1_s1[1]) * 45'(e2_s1[2]) - 45'(e1_s1[2]) * 45'(e2_s1[1]));
			side_s2.nrm_y <= 47'(45'(e1_s1[2]) * 45'(e2_s1[0]) - 45'(e1_s1[0]) * 45'(e2_s1[2]));
			side_s2.nrm_z <= 47'(45'(e1_s1[0]) * 45'(e2_s1[1]) - 45'(e1_s1[1]) * 45'(e2_s1[0]));
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			side_s8 <= side_s7;
			side_s9 <= side_s8;

			det_s4 <= dot_sum(det_lo_s3[0], det_hi_s3[0], det_lo_s3[1], det_hi_s3[1],
				det_lo_s3[2], det_hi_s3[2]);
			nu_s4  <= dot_sum(nu_lo_s3[0], nu_hi_s3[0], nu_lo_s3[1], nu_hi_s3[1],
				nu_lo_s3[2], nu_hi_s3[2]);
			nv_s4  <= dot_sum(nv_lo_s3[0], nv_hi_s3[0], nv_lo_s3[1], nv_hi_s3[1],
				nv_lo_s3[2], nv_hi_s3[2]);
			nt_s4  <= dot_sum(nt_lo_s3[0], nt_hi_s3[0], nt_lo_s3[1], nt_hi_s3[1],
				nt_lo_s3[2], nt_hi_s3[2]);

			// sign normalisation so that det is never negative
			det_s5 <= det_s4[DW-1] ? -det_s4 : det_s4;
			nu_s5  <= det_s4[DW-1] ? -nu_s4 : nu_s4;
			nv_s5  <= det_s4[DW-1] ? -nv_s4 : nv_s4;
			nt_s5  <= det_s4[DW-1] ? -nt_s4 : nt_s4;

			par_s6 <= (det_s5 == '0) || (det_s5 < $signed(DW'(tolerance)));
			det_s6 <= det_s5;
			nu_s6  <= nu_s5;
			nv_s6  <= nv_s5;
			nt_s6  <= nt_s5;

			dt_s7  <= $signed(CW'(pp_s6[0]) + (CW'(pp_s6[1]) << 23) + (CW'(pp_s6[2]) << 46));
			par_s7 <= par_s6;
			det_s7 <= det_s6;
			nu_s7  <= nu_s6;
			nv_s7  <= nv_s6;
			nt_s7  <= nt_s6;

			one_e_s8 <= (CW'(det_s7) <<< rti_pkg::FRAC_T) + dt_s7;
			neg_e_s8 <= -dt_s7;
			dt_s8    <= dt_s7;
			par_s8   <= par_s7;
			det_s8   <= det_s7;
			nu_s8    <= nu_s7;
			nv_s8    <= nv_s7;
			nt_s8    <= nt_s7;

			outcome_s9 <= outcome_d;
			det_s9     <= det_s8;
			nt_s9      <= nt_s8;
		end
	end

	always_comb begin
		nu16 = CW'(nu_s8) <<< rti_pkg::FRAC_T;
		nv16 = CW'(nv_s8) <<< rti_pkg::FRAC_T;
		nt16 = CW'(nt_s8) <<< rti_pkg::FRAC_T;
		uv16 = (CW'(nu_s8) + CW'(nv_s8)) <<< rti_pkg::FRAC_T;
		if (par_s8) begin
			outcome_d = rti_pkg::OUT_PARALLEL;
		end else if (nu16 < neg_e_s8 || nu16 > one_e_s8) begin
			outcome_d = rti_pkg::OUT_U_OUTSIDE;
		end else if (nv16 < neg_e_s8 || uv16 > one_e_s8) begin
			outcome_d = rti_pkg::OUT_V_OUTSIDE;
		end else if (nt16 <= dt_s8) begin
			outcome_d = rti_pkg::OUT_BEHIND;
		end else begin
			outcome_d = rti_pkg::OUT_HIT;
		end
	end

	always_comb begin
		push_item.outcome = outcome_s9;
		push_item.num     = nt_s9;
		push_item.den     = det_s9;
		push_item.org     = side_s9.org;
		push_item.dir     = side_s9.dir;
		if (outcome_s9 == rti_pkg::OUT_HIT) begin
			push_item.nrm_x = side_s9.nrm_x;
			push_item.nrm_y = side_s9.nrm_y;
			push_item.nrm_z = side_s9.nrm_z;
		end else begin
			push_item.nrm_x = '0;
			push_item.nrm_y = '0;
			push_item.nrm_z = '0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rti_back.sv
// rti_back: pipelined restoring divider for t, contact point and the output register
// depends on rti_pkg; drains rti_queue
`default_nettype none

module rti_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rti_pkg::q_item_t                  head_item,
	input  logic                              queue_empty,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        outcome,
	output logic [rti_pkg::DIST_W-1:0]        distance,
	output logic [rti_pkg::VEC_W-1:0]         hit_point,
	output logic signed [rti_pkg::NRM_W-1:0]  normal_x,
	output logic signed [rti_pkg::NRM_W-1:0]  normal_y,
	output logic signed [rti_pkg::NRM_W-1:0]  normal_z
);

	localparam int NS = rti_pkg::DIST_W;
	localparam int RW = rti_pkg::REM_W;
	localparam int CW = rti_pkg::CMP_W;

	function automatic logic [rti_pkg::COMP_W-1:0] sat21(input logic signed [38:0] v);
		if (v > 39'sd1048575) begin
			return 21'h0FFFFF;
		end else if (v < -39'sd1048576) begin
			return 21'h100000;
		end else begin
			return v[20:0];
		end
	endfunction

	logic en;
	logic out_valid_q;

	assign en        = !out_valid_q || !out_stall;
	assign pop       = en && !queue_empty;
	assign out_valid = out_valid_q;

	logic [NS+1:0]           valid_s;
	rti_pkg::q_item_t        div_item_s [0:NS];
	logic [RW-1:0]           div_rem_s  [0:NS];
	logic [NS-1:0]           div_quo_s  [0:NS];
	logic                    div_sat_s  [0:NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s     <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s     <= {valid_s[NS:0], pop};
			out_valid_q <= valid_s[NS+1];
		end
	end

	// load: t saturates when nt >= det << 16
	always_ff @(posedge clk) begin
		if (en) begin
			div_item_s[0] <= head_item;
			div_rem_s[0]  <= RW'(head_item.num) << rti_pkg::FRAC_T;
			div_quo_s[0]  <= '0;
			div_sat_s[0]  <= CW'(head_item.num) >= (CW'(head_item.den) <<< rti_pkg::FRAC_T);
		end
	end

	for (genvar k = 1; k <= NS; k++) begin : g_div
		localparam int SH = NS - k;
		logic [RW-1:0] dsh;

		assign dsh = RW'(div_item_s[k-1].den) << SH;

		always_ff @(posedge clk) begin
			if (en) begin
				div_item_s[k] <= div_item_s[k-1];
				div_sat_s[k]  <= div_sat_s[k-1];
				if (div_rem_s[k-1] >= dsh) begin
					div_rem_s[k] <= div_rem_s[k-1] - dsh;
					div_quo_s[k] <= div_quo_s[k-1] | (NS'(1) << SH);
				end else begin
					div_rem_s[k] <= div_rem_s[k-1];
					div_quo_s[k] <= div_quo_s[k-1];
				end
			end
		end
	end

	// direction times t, then shift, add origin and saturate
	logic [NS-1:0]       dist_m1;
	logic signed [53:0]  prod_m1 [3];
	rti_pkg::q_item_t    item_m1;
	logic [NS-1:0]       dist_sel;

	assign dist_sel = div_sat_s[NS] ? '1 : div_quo_s[NS];

	for (genvar k = 0; k < 3; k++) begin : g_mul
		always_ff @(posedge clk) begin
			if (en) begin
				prod_m1[k] <= 54'(rti_pkg::comp(div_item_s[NS].dir, k))
					* 54'($signed({1'b0, dist_sel}));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_m1 <= dist_sel;
			item_m1 <= div_item_s[NS];
		end
	end

	logic                  hit_m1;
	logic [rti_pkg::VEC_W-1:0] cp_d;

	assign hit_m1 = (item_m1.outcome == rti_pkg::OUT_HIT);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cp_d[k*rti_pkg::COMP_W +: rti_pkg::COMP_W] =
				sat21(39'(prod_m1[k] >>> rti_pkg::FRAC_T) + 39'(rti_pkg::comp(item_m1.org, k)));
		end
	end

	logic [2:0]                        outcome_q;
	logic [rti_pkg::DIST_W-1:0]        distance_q;
	logic [rti_pkg::VEC_W-1:0]         contact_q;
	logic signed [rti_pkg::NRM_W-1:0]  nrm_x_q, nrm_y_q, nrm_z_q;

	always_ff @(posedge clk) begin
		if (en) begin
			outcome_q  <= item_m1.outcome;
			distance_q <= hit_m1 ? dist_m1 : '0;
			contact_q  <= hit_m1 ? cp_d : '0;
			nrm_x_q    <= item_m1.nrm_x;
			nrm_y_q    <= item_m1.nrm_y;
			nrm_z_q    <= item_m1.nrm_z;
		end
	end

	assign outcome   = outcome_q;
	assign distance  = distance_q;
	assign hit_point = contact_q;
	assign normal_x  = nrm_x_q;
	assign normal_y  = nrm_y_q;
	assign normal_z  = nrm_z_q;

endmodule

`default_nettype wire

FILE: rtl/ray_triangle_intersection_core.sv
// ray_triangle_intersection_core: fixed-point ray/triangle test, top level
// depends on rti_pkg, rti_front, rti_queue and rti_back
//
// usage:
//   input channel (in_valid / in_stall) takes one transaction per test: ray origin,
//   ray direction and three vertices, each three packed signed Q10.10 components
//   output channel (out_valid / out_stall) returns exactly one transaction per test,
//   in order: outcome, distance t (Q16.16), contact point and unnormalised normal
//   cfg channel (cfg_valid / cfg_ready) writes the tolerance; cfg_ready is always high;
//   a write must be made only while no test is in flight; the block itself does not enforce it
// throughput: one test per cycle while no stall holds the flow; set by the 9-stage front pipeline
//   and the 32-stage divider, each divider stage a single compare/subtract
// path: after the accepting edge a test passes the 8 further front stages, the queue write,
//   the load, the 32 divider stages and the 2 contact stages before out_valid rises
// reset: clears all valid flags and the queue; tolerance returns to 1
// stall: a stalled output freezes the divider side; the front keeps running until the
//   queue fills, and only then raises in_stall
`default_nettype none

module ray_triangle_intersection_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rti_pkg::TOL_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rti_pkg::VEC_W-1:0]         ray_origin,
	input  logic [rti_pkg::VEC_W-1:0]         ray_direction,
	input  logic [rti_pkg::VEC_W-1:0]         vertex_a,
	input  logic [rti_pkg::VEC_W-1:0]         vertex_b,
	input  logic [rti_pkg::VEC_W-1:0]         vertex_c,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        outcome,
	output logic [rti_pkg::DIST_W-1:0]        distance,
	output logic [rti_pkg::VEC_W-1:0]         hit_point,
	output logic signed [rti_pkg::NRM_W-1:0]  normal_x,
	output logic signed [rti_pkg::NRM_W-1:0]  normal_y,
	output logic signed [rti_pkg::NRM_W-1:0]  normal_z
);

	localparam int QW = $bits(rti_pkg::q_item_t);

	logic [rti_pkg::TOL_W-1:0] tolerance_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= rti_pkg::TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tolerance_q <= cfg_data;
		end
	end

	logic             push, pop, q_full, q_empty;
	rti_pkg::q_item_t push_item;
	logic [QW-1:0]    pop_data;

	rti_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.tolerance     (tolerance_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.ray_origin    (ray_origin),
		.ray_direction (ray_direction),
		.vertex_a      (vertex_a),
		.vertex_b      (vertex_b),
		.vertex_c      (vertex_c),
		.queue_full    (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	rti_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (QW'(push_item)),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	rti_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_item   (rti_pkg::q_item_t'(pop_data)),
		.queue_empty (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.outcome     (outcome),
		.distance    (distance),
		.hit_point   (hit_point),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z)
	);

endmodule

`default_nettype wire

FILE: tb/tb_ray_triangle_intersection_core.sv
// testbench for ray_triangle_intersection_core: streams ray/triangle tests, predicts
// each outcome in a scoreboard class and checks every output transaction in order
// depends on rti_pkg and the core rtl
`timescale 1ns / 1ps

module tb_ray_triangle_intersection_core;

	typedef logic signed [127:0] wide_t;
	typedef wide_t vec3_t [3];

	typedef struct {
		rti_pkg::outcome_t kind;
		logic [31:0]  t_dist;
		logic [62:0]  cp;
		logic [46:0]  nx, ny, nz;
	} hit_report_t;

	class intersect_board;
		logic [19:0]  tol;
		hit_report_t  pending_q[$];
		int           errors;

		function new();
			tol = rti_pkg::TOL_RESET;
			errors = 0;
		endfunction

		function vec3_t unpack3(logic [62:0] w);
			vec3_t r;
			for (int k = 0; k < 3; k++)
				r[k] = $signed(w[k*21 +: 21]);
			return r;
		endfunction

		function vec3_t cross3(vec3_t a, vec3_t b);
			vec3_t r;
			r[0] = a[1]*b[2] - a[2]*b[1];
			r[1] = a[2]*b[0] - a[0]*b[2];
			r[2] = a[0]*b[1] - a[1]*b[0];
			return r;
		endfunction

		function wide_t dot3(vec3_t a, vec3_t b);
			return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
		endfunction

		// note an accepted test and queue the outcome it must produce
		function void note_test(logic [62:0] o, d, a, b, c);
			vec3_t org, dir, va, e1, e2, s, p, q, n;
			wide_t det, nu, nv, nt, tolw, one_e, tol_e, lhs, tv, cc;
			hit_report_t r;
			org = unpack3(o); dir = unpack3(d); va = unpack3(a);
			e1 = unpack3(b); e2 = unpack3(c);
			for (int k = 0; k < 3; k++) begin
				e1[k] = e1[k] - va[k];
				e2[k] = e2[k] - va[k];
				s[k] = org[k] - va[k];
			end
			p = cross3(dir, e2);
			q = cross3(s, e1);
			n = cross3(e1, e2);
			det = dot3(e1, p); nu = dot3(s, p); nv = dot3(dir, q); nt = dot3(e2, q);
			r = '{rti_pkg::OUT_HIT, 0, 0, 0, 0, 0};
			if (det < 0) begin
				det = -det; nu = -nu; nv = -nv; nt = -nt;
			end
			tolw = {108'd0, tol};
			one_e = det * (tolw + 65536);
			tol_e = det * tolw;
			if (det == 0 || det < tolw)
				r.kind = rti_pkg::OUT_PARALLEL;
			else if ((nu <<< 16) < -tol_e || (nu <<< 16) > one_e)
				r.kind = rti_pkg::OUT_U_OUTSIDE;
			else if ((nv <<< 16) < -tol_e || ((nu + nv) <<< 16) > one_e)
				r.kind = rti_pkg::OUT_V_OUTSIDE;
			else if ((nt <<< 16) <= tol_e)
				r.kind = rti_pkg::OUT_BEHIND;
			else begin
				lhs = nt <<< 16;
				if (lhs >= (det <<< 32))
					r.t_dist = 32'hFFFF_FFFF;
				else
					r.t_dist = 32'(lhs / det);
				tv = {96'd0, r.t_dist};
				for (int k = 0; k < 3; k++) begin
					cc = org[k] + ((dir[k] * tv) >>> 16);
					if (cc > 1048575) cc = 1048575;
					if (cc < -1048576) cc = -1048576;
					r.cp[k*21 +: 21] = cc[20:0];
				end
				r.nx = n[0][46:0]; r.ny = n[1][46:0]; r.nz = n[2][46:0];
			end
			pending_q.push_back(r);
		endfunction

		function void check_result(hit_report_t got);
			hit_report_t want;
			if (pending_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.kind !== want.kind) begin
				$error("outcome: expected %0d, got %0d", want.kind, got.kind); errors++;
			end
			if (got.t_dist !== want.t_dist) begin
				$error("distance: expected %h, got %h", want.t_dist, got.t_dist); errors++;
			end
			if (got.cp !== want.cp) begin
				$error("hit_point: expected %h, got %h", want.cp, got.cp); errors++;
			end
			if (got.nx !== want.nx) begin
				$error("normal_x: expected %h, got %h", want.nx, got.nx); errors++;
			end
			if (got.ny !== want.ny) begin
				$error("normal_y: expected %h, got %h", want.ny, got.ny); errors++;
			end
			if (got.nz !== want.nz) begin
				$error("normal_z: expected %h, got %h", want.nz, got.nz); errors++;
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [19:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [62:0] ray_origin = '0, ray_direction = '0;
	logic [62:0] vertex_a = '0, vertex_b = '0, vertex_c = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  outcome;
	logic [31:0] distance;
	logic [62:0] hit_point;
	logic signed [46:0] normal_x, normal_y, normal_z;

	intersect_board board = new();
	int  tests_sent = 0;
	int  hold_cycles = 0;
	bit  hold_done = 0;
	int  quiet_cycles = 0;
	int  burst_left = 0;

	ray_triangle_intersection_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.ray_origin(ray_origin), .ray_direction(ray_direction),
		.vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
		.out_valid(out_valid), .out_stall(out_stall), .outcome(outcome),
		.distance(distance), .hit_point(hit_point),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// both monitors sample at the rising edge
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			board.note_test(ray_origin, ray_direction, vertex_a, vertex_b, vertex_c);
		if (out_valid && !out_stall)
			board.check_result('{rti_pkg::outcome_t'(outcome), distance, hit_point,
				normal_x, normal_y, normal_z});
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_ray_triangle_intersection_core: done, errors");
			$finish;
		end
	end

	// receiver: stall pattern redrawn at random at regular intervals, plus one long hold-off
	always @(negedge clk) begin
		static int rx_mode = 0;
		static int rx_cnt = 0;
		rx_cnt++;
		if (rx_cnt % 256 == 0)
			rx_mode = $urandom_range(0, 3);
		if (!hold_done && tests_sent >= 900) begin
			hold_done = 1;
			hold_cycles = 400;
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall = 1'b1;
		end else begin
			case (rx_mode)
				0: out_stall = 1'b0;
				1: out_stall = ($urandom_range(0, 99) < 30);
				2: out_stall = (rx_cnt % 16) >= 11;
				default: out_stall = ($urandom_range(0, 99) < 75);
			endcase
		end
	end

	function automatic logic [62:0] pack3(int x, int y, int z);
		logic [62:0] w;
		w[20:0] = x[20:0];
		w[41:21] = y[20:0];
		w[62:42] = z[20:0];
		return w;
	endfunction

	function automatic int rnd_comp(int span);
		return int'($urandom_range(0, 2*span)) - span;
	endfunction

	task automatic send_test(logic [62:0] o, d, a, b, c);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				in_valid = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid = 1'b1;
		ray_origin = o; ray_direction = d;
		vertex_a = a; vertex_b = b; vertex_c = c;
		do @(posedge clk); while (in_stall);
		tests_sent++;
		@(negedge clk);
	endtask

	task automatic finish_sending();
		in_valid = 1'b0;
		wait (board.pending_q.size() == 0);
		repeat (60) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_tolerance(logic [19:0] value);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		board.tol = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly rays aimed at a point in or near the triangle, some from behind, some noise
	task automatic random_test();
		int span, w1, w2, sel;
		int a[3], b[3], c[3], o[3], t[3], d[3];
		sel = $urandom_range(0, 99);
		span = ($urandom_range(0, 15) == 0) ? 1048575 : (1 << $urandom_range(4, 14));
		if (sel < 20) begin
			send_test(63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
				63'({$urandom, $urandom}), 63'({$urandom, $urandom}),
				63'({$urandom, $urandom}));
			return;
		end
		w1 = $urandom_range(0, 280);
		w2 = $urandom_range(0, 280 - w1);
		for (int k = 0; k < 3; k++) begin
			a[k] = rnd_comp(span); b[k] = rnd_comp(span); c[k] = rnd_comp(span);
			o[k] = rnd_comp(span);
			t[k] = a[k] + ((b[k] - a[k]) * w1 + (c[k] - a[k]) * w2) / 256;
			d[k] = t[k] - o[k];
			if (sel < 30) d[k] = -d[k];
			else if (sel < 40) d[k] = d[k] / int'($urandom_range(1, 4096));
		end
		send_test(pack3(o[0], o[1], o[2]), pack3(d[0], d[1], d[2]),
			pack3(a[0], a[1], a[2]), pack3(b[0], b[1], b[2]), pack3(c[0], c[1], c[2]));
	endtask

	initial begin
		logic [19:0] tol_plan[5];
		tol_plan = '{20'd0, 20'hFFFFF, 20'd65536, 20'd1, 20'd0};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: degenerate, extreme words, clean hits, behind, tiny direction, u and v outside
		send_test('0, '0, '0, '0, '0);
		send_test('1, '1, '1, '1, '1);
		send_test({63{1'b1}}, pack3(1, 0, 0), '0, pack3(1, 0, 0), pack3(0, 1, 0));
		send_test(pack3(256, 256, -1024), pack3(0, 0, 1024), pack3(0, 0, 0),
			pack3(1024, 0, 0), pack3(0, 1024, 0));
		send_test(pack3(256, 256, 1024), pack3(0, 0, 1024), pack3(0, 0, 0),
			pack3(1024, 0, 0), pack3(0, 1024, 0));
		send_test(pack3(256, 256, -1024), pack3(0, 0, 1), pack3(0, 0, 0),
			pack3(1024, 0, 0), pack3(0, 1024, 0));
		send_test(pack3(2048, 256, -1024), pack3(0, 0, 1024), pack3(0, 0, 0),
			pack3(1024, 0, 0), pack3(0, 1024, 0));
		send_test(pack3(256, 2048, -1024), pack3(0, 0, 1024), pack3(0, 0, 0),
			pack3(1024, 0, 0), pack3(0, 1024, 0));
		send_test(pack3(700, 700, -1024), pack3(0, 0, 1024), pack3(0, 0, 0),
			pack3(1024, 0, 0), pack3(0, 1024, 0));
		send_test(pack3(0, 0, 1024), pack3(0, 0, -1024), pack3(0, 0, 0),
			pack3(0, 1024, 0), pack3(1024, 0, 0));
		send_test(pack3(1024, 0, -1024), pack3(0, 0, 1024), pack3(0, 0, 0),
			pack3(1024, 0, 0), pack3(0, 1024, 0));
		send_test(pack3(-1048576, 1048575, -1048576), pack3(1048575, -1048576, 1048575),
			pack3(1048575, 1048575, -1048576), pack3(-1048576, -1048576, 1048575),
			pack3(1048575, -1048576, 0));
		send_test(pack3(1048575, 1048575, -1048576), pack3(0, 0, 1048575),
			pack3(-1048576, -1048576, 0), pack3(1048575, -1048576, 0),
			pack3(0, 1048575, 0));
		send_test(pack3(0, 0, 0), pack3(1024, 0, 0), pack3(0, 0, 0),
			pack3(1024, 0, 0), pack3(2048, 0, 0));
		for (int i = 0; i < 300; i++)
			random_test();
		finish_sending();

		foreach (tol_plan[ph]) begin
			write_tolerance(tol_plan[ph]);
			for (int i = 0; i < 310; i++)
				random_test();
			finish_sending();
		end

		if (board.errors == 0)
			$display("tb_ray_triangle_intersection_core: done, clean");
		else
			$display("tb_ray_triangle_intersection_core: done, errors");
		$finish;
	end

endmodule

FILE: ray_triangle_intersection_core.f
rtl/rti_pkg.sv
rtl/rti_queue.sv
rtl/rti_front.sv
rtl/rti_back.sv
rtl/ray_triangle_intersection_core.sv
tb/tb_ray_triangle_intersection_core.sv
